/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the word filter RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property checked on every rising edge outside reset.
`define WLF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that must never become true outside reset.
`define WLF_ASSERT_NEVER(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(prop)) else $error(msg);

`endif

/* hw/rtl/wlf_pkg.sv */
// Package for the word filter: constants, register indexes and shared structs.
// No dependencies; used by every RTL module of the block.
package wlf_pkg;

   localparam int MAX_AFFIX    = 8;
   localparam int AFFIX_IDX_W  = $clog2(MAX_AFFIX);
   localparam int AFFIX_LEN_W  = 4;
   localparam int LEN_W        = 8;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_IDX_W    = 3;
   localparam int NUM_TESTS    = 5;
   localparam int SET_W        = 64;

   localparam logic [LEN_W-1:0] MAX_WORD_LEN = 8'd255;
   localparam logic [7:0]       END_OF_WORD  = 8'd10;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_TEST_ENABLES  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REQUIRED_SET  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALLOWED_SET   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LENGTH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_BYTES  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SUFFIX_BYTES  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_AFFIX_LENGTHS = 3'd7;

   // Bit positions in test_enables and failed_tests
   localparam int TEST_REQUIRED = 0;
   localparam int TEST_ALLOWED  = 1;
   localparam int TEST_LENGTH   = 2;
   localparam int TEST_PREFIX   = 3;
   localparam int TEST_SUFFIX   = 4;

   typedef struct packed {
      logic [NUM_TESTS-1:0] test_enables;
      logic [SET_W-1:0]     required_set;
      logic [SET_W-1:0]     allowed_set;
      logic [LEN_W-1:0]     min_length;
      logic [LEN_W-1:0]     max_length;
      logic [63:0]          prefix_bytes;
      logic [63:0]          suffix_bytes;
      logic [7:0]           affix_lengths;
   } cfg_type;

   typedef struct packed {
      logic                 accepted;
      logic [LEN_W-1:0]     word_length;
      logic [NUM_TESTS-1:0] failed_tests;
   } result_type;

endpackage

/* hw/rtl/word_list_filter.sv */
// Top level of the word filter: registers, word tracker and result buffer.
// Depends on wlf_pkg, wlf_csr, wlf_track and wlf_rsp_buf.
//
// Usage:
//  - req channel carries one text byte per transaction (req_char_byte).
//    A newline (10) ends the word; every other byte belongs to it.
//  - rsp channel carries one verdict per newline: rsp_accepted,
//    rsp_word_length (saturating at 255) and rsp_failed_tests.
//  - csr port writes the eight filter registers by index; write only
//    while no word verdict is outstanding.
//  - Throughput: one byte per cycle while req_stall is low. Each accepted
//    byte updates the running per-word flags.
//  - The verdict is registered in the result register when the newline
//    is accepted, or in the skid stage while the output is stalled.
//  - A result register plus a one-entry skid stage sit on the rsp side,
//    so bytes keep flowing while one verdict waits; req_stall rises only
//    when a second verdict is parked behind a stalled output.
//  - Reset (synchronous, active high) restores register defaults and
//    clears the word state and both result slots; no clearing pass.
module word_list_filter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_char_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_accepted,
   output logic [wlf_pkg::LEN_W-1:0]       rsp_word_length,
   output logic [wlf_pkg::NUM_TESTS-1:0]   rsp_failed_tests,
   input  logic                            csr_write,
   input  logic [wlf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wlf_pkg::CSR_DATA_W-1:0]  csr_data
);

   wlf_pkg::cfg_type     cfg;
   wlf_pkg::result_type  verdict;
   wlf_pkg::result_type  rsp_data;
   logic                 req_accept;
   logic                 buf_full;
   logic                 push;

   assign req_stall  = buf_full;
   assign req_accept = req_valid && !req_stall;
   assign push       = req_accept && (req_char_byte == wlf_pkg::END_OF_WORD);

   wlf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   wlf_track u_track (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .byte_accept (req_accept),
      .char_byte   (req_char_byte),
      .verdict     (verdict)
   );

   wlf_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (verdict),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_accepted     = rsp_data.accepted;
   assign rsp_word_length  = rsp_data.word_length;
   assign rsp_failed_tests = rsp_data.failed_tests;

endmodule

/* hw/rtl/wlf_csr.sv */
// Configuration register file of the word filter.
// Depends on wlf_pkg for register indexes and the cfg_type struct.
module wlf_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [wlf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wlf_pkg::CSR_DATA_W-1:0]    csr_data,
   output wlf_pkg::cfg_type                  cfg
);

   wlf_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            wlf_pkg::CSR_TEST_ENABLES:
               cfg_in.test_enables = csr_data[wlf_pkg::NUM_TESTS-1:0];
            wlf_pkg::CSR_REQUIRED_SET:  cfg_in.required_set  = csr_data;
            wlf_pkg::CSR_ALLOWED_SET:   cfg_in.allowed_set   = csr_data;
            wlf_pkg::CSR_MIN_LENGTH:    cfg_in.min_length    = csr_data[wlf_pkg::LEN_W-1:0];
            wlf_pkg::CSR_MAX_LENGTH:    cfg_in.max_length    = csr_data[wlf_pkg::LEN_W-1:0];
            wlf_pkg::CSR_PREFIX_BYTES:  cfg_in.prefix_bytes  = csr_data;
            wlf_pkg::CSR_SUFFIX_BYTES:  cfg_in.suffix_bytes  = csr_data;
            wlf_pkg::CSR_AFFIX_LENGTHS: cfg_in.affix_lengths = csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.test_enables  <= '0;
         cfg_ff.required_set  <= '0;
         cfg_ff.allowed_set   <= '1;
         cfg_ff.min_length    <= '0;
         cfg_ff.max_length    <= '1;
         cfg_ff.prefix_bytes  <= '0;
         cfg_ff.suffix_bytes  <= '0;
         cfg_ff.affix_lengths <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/wlf_track.sv */
// Per-word running flags and the verdict logic evaluated at end of word.
// Depends on wlf_pkg for constants and the cfg_type / result_type structs.
module wlf_track (
   input  logic                   clock,
   input  logic                   reset,
   input  wlf_pkg::cfg_type       cfg,
   input  logic                   byte_accept,
   input  logic [7:0]             char_byte,
   output wlf_pkg::result_type    verdict
);

   logic [wlf_pkg::SET_W-1:0]  seen_ff, seen_in;
   logic                       all_ok_ff, all_ok_in;
   logic [wlf_pkg::LEN_W-1:0]  len_ff, len_in;
   logic                       pmatch_ff, pmatch_in;
   logic [7:0]                 recent_ff [wlf_pkg::MAX_AFFIX];
   logic [7:0]                 recent_in [wlf_pkg::MAX_AFFIX];

   logic [wlf_pkg::AFFIX_LEN_W-1:0] plen, slen;
   logic [wlf_pkg::LEN_W-1:0]       plen_ext, slen_ext;
   logic                            is_letter;
   logic [wlf_pkg::SET_W-1:0]       letter_bit;
   logic [7:0]                      prefix_char;
   logic                            suffix_ok;
   logic [wlf_pkg::NUM_TESTS-1:0]   raw_fail;

   always_comb begin
      plen = (cfg.affix_lengths[3:0] > wlf_pkg::AFFIX_LEN_W'(wlf_pkg::MAX_AFFIX))
             ? wlf_pkg::AFFIX_LEN_W'(wlf_pkg::MAX_AFFIX) : cfg.affix_lengths[3:0];
      slen = (cfg.affix_lengths[7:4] > wlf_pkg::AFFIX_LEN_W'(wlf_pkg::MAX_AFFIX))
             ? wlf_pkg::AFFIX_LEN_W'(wlf_pkg::MAX_AFFIX) : cfg.affix_lengths[7:4];
      plen_ext = wlf_pkg::LEN_W'(plen);
      slen_ext = wlf_pkg::LEN_W'(slen);
   end

   // Codes 64..127 map onto the 64-bit letter masks
   assign is_letter   = (char_byte[7:6] == 2'b01);
   assign letter_bit  = wlf_pkg::SET_W'(1) << char_byte[5:0];
   assign prefix_char = cfg.prefix_bytes[{len_ff[wlf_pkg::AFFIX_IDX_W-1:0], 3'b000} +: 8];

   always_comb begin
      seen_in   = seen_ff;
      all_ok_in = all_ok_ff;
      len_in    = len_ff;
      pmatch_in = pmatch_ff;
      for (int i = 0; i < wlf_pkg::MAX_AFFIX; i++) begin
         recent_in[i] = recent_ff[i];
      end
      if (byte_accept) begin
         if (char_byte == wlf_pkg::END_OF_WORD) begin
            seen_in   = '0;
            all_ok_in = 1'b1;
            len_in    = '0;
            pmatch_in = 1'b1;
            for (int i = 0; i < wlf_pkg::MAX_AFFIX; i++) begin
               recent_in[i] = '0;
            end
         end else begin
            if (is_letter) begin
               seen_in = seen_ff | letter_bit;
               if ((cfg.allowed_set & letter_bit) == '0) begin
                  all_ok_in = 1'b0;
               end
            end else begin
               all_ok_in = 1'b0;
            end
            if (len_ff < plen_ext && char_byte != prefix_char) begin
               pmatch_in = 1'b0;
            end
            recent_in[0] = char_byte;
            for (int i = 1; i < wlf_pkg::MAX_AFFIX; i++) begin
               recent_in[i] = recent_ff[i-1];
            end
            if (len_ff < wlf_pkg::MAX_WORD_LEN) begin
               len_in = len_ff + wlf_pkg::LEN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff   <= '0;
         all_ok_ff <= 1'b1;
         len_ff    <= '0;
         pmatch_ff <= 1'b1;
         for (int i = 0; i < wlf_pkg::MAX_AFFIX; i++) begin
            recent_ff[i] <= '0;
         end
      end else begin
         seen_ff   <= seen_in;
         all_ok_ff <= all_ok_in;
         len_ff    <= len_in;
         pmatch_ff <= pmatch_in;
         for (int i = 0; i < wlf_pkg::MAX_AFFIX; i++) begin
            recent_ff[i] <= recent_in[i];
         end
      end
   end

   // Verdict on the word held in the running flags; used on a newline
   always_comb begin
      suffix_ok = (len_ff >= slen_ext);
      for (int i = 0; i < wlf_pkg::MAX_AFFIX; i++) begin
         if (wlf_pkg::AFFIX_LEN_W'(i) < slen && recent_ff[i] != cfg.suffix_bytes[8*i +: 8]) begin
            suffix_ok = 1'b0;
         end
      end
      raw_fail = '0;
      raw_fail[wlf_pkg::TEST_REQUIRED] = ((cfg.required_set & ~seen_ff) != '0);
      raw_fail[wlf_pkg::TEST_ALLOWED]  = !all_ok_ff;
      raw_fail[wlf_pkg::TEST_LENGTH]   = (len_ff < cfg.min_length) || (len_ff > cfg.max_length);
      raw_fail[wlf_pkg::TEST_PREFIX]   = !pmatch_ff || (len_ff < plen_ext);
      raw_fail[wlf_pkg::TEST_SUFFIX]   = !suffix_ok;
      verdict.failed_tests = raw_fail & cfg.test_enables;
      verdict.accepted     = (verdict.failed_tests == '0);
      verdict.word_length  = len_ff;
   end

endmodule

/* hw/rtl/wlf_rsp_buf.sv */
// Result register with a one-entry skid stage for the word filter.
// Depends on wlf_pkg for result_type and on assert_macros.svh for checks.
`include "assert_macros.svh"

module wlf_rsp_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  wlf_pkg::result_type    push_data,
   output logic                   full,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output wlf_pkg::result_type    rsp_data
);

   logic                  out_valid_ff, out_valid_in;
   wlf_pkg::result_type   out_data_ff, out_data_in;
   logic                  skid_valid_ff, skid_valid_in;
   wlf_pkg::result_type   skid_data_ff, skid_data_in;
   logic                  out_free;

   // Output slot can load when empty or being taken this cycle
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `WLF_ASSERT(a_skid_behind_out, clock, reset, skid_valid_ff |-> out_valid_ff, "skid holds a result while output slot is empty")
   `WLF_ASSERT_NEVER(a_no_push_when_full, clock, reset, push && skid_valid_ff, "result pushed into a full buffer")
   `WLF_ASSERT(a_skid_drains, clock, reset, (skid_valid_ff && !rsp_stall) |=> (out_valid_ff && !skid_valid_ff), "skid entry not moved to output")
   `WLF_ASSERT(a_verdict_consistent, clock, reset, out_valid_ff |-> (out_data_ff.accepted == (out_data_ff.failed_tests == '0)), "accepted flag disagrees with failed tests")

endmodule
